FILE: design/spectrometer_readout_sequencer_top_defines.svh
// assertion macros shared by the readout sequencer checker
`ifndef SPECTROMETER_READOUT_SEQUENCER_TOP_DEFINES_SVH
`define SPECTROMETER_READOUT_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SRS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SRS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/srs_pkg.sv
// shared types, constants and helpers of the readout sequencer
`default_nettype none

package srs_pkg;

    localparam int CNT_W        = 20;
    localparam int CFG_W        = 20;
    localparam int START_W      = 18;
    localparam int PIX_IDX_W    = 9;
    localparam int SAMPLE_W     = 8;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 24;

    localparam int DEF_PIXEL_COUNT = 288;
    localparam int DEF_LEAD_CLOCKS = 88;

    localparam logic [CFG_W-1:0]   MIN_TIME_US      = CFG_W'(54 * 4);
    localparam logic [START_W-1:0] START_OFFSET     = START_W'(48);
    localparam logic [START_W-1:0] START_PULSES_RST = START_W'(6);

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_BEGIN = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_FIRST = 3'd1,
        PH_INTEG = 3'd2,
        PH_GAP   = 3'd3,
        PH_LEAD  = 3'd4,
        PH_PIXEL = 3'd5
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [CNT_W-1:0]   pulse_counter;
        logic               half_period_flag;
        logic               clock_line;
        logic               start_line;
    } srs_state_t;

    typedef struct packed {
        logic                 clock_level;
        logic                 start_level;
        logic                 pixel_valid;
        logic [PIX_IDX_W-1:0] pixel_index;
        logic [SAMPLE_W-1:0]  pixel_value;
        logic                 last_pixel;
        logic                 busy_res;
    } srs_result_t;

    // start-high pulse count: max(t, 216) / 4 - 48
    function automatic logic [START_W-1:0] start_pulses(input logic [CFG_W-1:0] t);
        logic [CFG_W-1:0] t_eff;
        t_eff = (t < MIN_TIME_US) ? MIN_TIME_US : t;
        return t_eff[CFG_W-1:2] - START_OFFSET;
    endfunction

endpackage

`default_nettype wire

FILE: design/srs_step.sv
// next-state and result logic for one tick or begin request
`default_nettype none

module srs_step
    import srs_pkg::*;
#(
    parameter int PIXEL_COUNT = DEF_PIXEL_COUNT,
    parameter int LEAD_CLOCKS = DEF_LEAD_CLOCKS
)
(
    input  wire srs_state_t             cur,
    input  wire                         op,
    input  wire [SAMPLE_W-1:0]          video_sample,
    input  wire [START_W-1:0]           start_pulses_n,
    output srs_state_t                  nxt,
    output srs_result_t                 res
);

    phase_t           ph;
    logic [CNT_W-1:0] cnt_inc;
    logic             pix_valid;
    logic             pix_last;

    assign cnt_inc = cur.pulse_counter + CNT_W'(1);

    // unused phase codes fall back to idle
    always_comb
    begin
        case (cur.phase)
            PH_FIRST, PH_INTEG, PH_GAP, PH_LEAD, PH_PIXEL: ph = cur.phase;
            default:                                      ph = PH_IDLE;
        endcase
    end

    always_comb
    begin
        nxt       = cur;
        nxt.phase = ph;
        pix_valid = 1'b0;
        pix_last  = 1'b0;
        if (op == OP_BEGIN)
        begin
            if (ph == PH_IDLE)
            begin
                nxt.clock_line       = 1'b1;
                nxt.start_line       = 1'b0;
                nxt.pulse_counter    = '0;
                nxt.half_period_flag = 1'b1;
                nxt.phase            = PH_FIRST;
            end
        end
        else
        begin
            case (ph)
                PH_FIRST:
                begin
                    nxt.clock_line       = 1'b0;
                    nxt.start_line       = 1'b1;
                    nxt.pulse_counter    = '0;
                    nxt.half_period_flag = 1'b0;
                    nxt.phase            = PH_INTEG;
                end
                PH_INTEG:
                begin
                    if (!cur.half_period_flag)
                    begin
                        nxt.clock_line       = 1'b1;
                        nxt.half_period_flag = 1'b1;
                    end
                    else
                    begin
                        nxt.clock_line       = 1'b0;
                        nxt.half_period_flag = 1'b0;
                        nxt.pulse_counter    = cnt_inc;
                        if (cnt_inc >= CNT_W'(start_pulses_n))
                        begin
                            nxt.start_line    = 1'b0;
                            nxt.pulse_counter = '0;
                            nxt.phase         = PH_GAP;
                        end
                    end
                end
                PH_GAP:
                begin
                    nxt.clock_line       = 1'b1;
                    nxt.half_period_flag = 1'b1;
                    nxt.pulse_counter    = '0;
                    nxt.phase            = (LEAD_CLOCKS > 0) ? PH_LEAD : PH_PIXEL;
                end
                PH_LEAD:
                begin
                    if (cur.half_period_flag)
                    begin
                        nxt.clock_line       = 1'b0;
                        nxt.half_period_flag = 1'b0;
                    end
                    else
                    begin
                        nxt.pulse_counter    = cnt_inc;
                        nxt.clock_line       = 1'b1;
                        nxt.half_period_flag = 1'b1;
                        if (cnt_inc >= CNT_W'(LEAD_CLOCKS))
                        begin
                            nxt.pulse_counter = '0;
                            nxt.phase         = PH_PIXEL;
                        end
                    end
                end
                PH_PIXEL:
                begin
                    if (cur.half_period_flag)
                    begin
                        nxt.clock_line       = 1'b0;
                        nxt.half_period_flag = 1'b0;
                    end
                    else
                    begin
                        pix_valid         = 1'b1;
                        nxt.pulse_counter = cnt_inc;
                        if (cnt_inc >= CNT_W'(PIXEL_COUNT))
                        begin
                            pix_last             = 1'b1;
                            nxt.pulse_counter    = '0;
                            nxt.clock_line       = 1'b0;
                            nxt.half_period_flag = 1'b0;
                            nxt.phase            = PH_IDLE;
                        end
                        else
                        begin
                            nxt.clock_line       = 1'b1;
                            nxt.half_period_flag = 1'b1;
                        end
                    end
                end
                default:
                begin
                    nxt.phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        res.clock_level = nxt.clock_line;
        res.start_level = nxt.start_line;
        res.pixel_valid = pix_valid;
        res.pixel_index = pix_valid ? cur.pulse_counter[PIX_IDX_W-1:0] : '0;
        res.pixel_value = pix_valid ? video_sample : '0;
        res.last_pixel  = pix_last;
        res.busy_res    = (nxt.phase != PH_IDLE);
    end

endmodule

`default_nettype wire

FILE: design/spectrometer_readout_sequencer_top.sv
// top level of the linear sensor readout sequencer
// Each slave transaction is either one 2 us time-base tick (tuser = 0) or a request to begin a
// readout (tuser = 1); every transaction yields exactly one master transaction carrying the clock
// and start line levels after that step, the busy flag and, at the end of each pixel pulse's low
// half, the captured video sample with its index. A readout is one clock high, start high for
// N clock pulses with N = max(integration_time_us, 216) / 4 - 48, one gap tick, LEAD_CLOCKS
// lead-in pulses and PIXEL_COUNT pixel pulses; the final pixel carries tlast. A begin request
// during a readout is ignored. Rate: one transaction per clock cycle sustained, with each result
// registered; the step logic sits between the state register and the output register, which also
// acts as the skid stage, so tready only drops while a result waits and m_tready is low.
// The integration time register may be written at any time; N is recomputed on the write
// and takes effect from the next tick on.
`default_nettype none

module spectrometer_readout_sequencer_top
    import srs_pkg::*;
#(
    parameter int PIXEL_COUNT = DEF_PIXEL_COUNT,
    parameter int LEAD_CLOCKS = DEF_LEAD_CLOCKS
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    // configuration write channel: integration_time_us
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire  [CFG_W-1:0]        cfg_data,
    // slave side
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  wire  [S_TDATA_W-1:0]    s_tdata,   // [7:0] video_sample
    input  wire                     s_tuser,   // [0] op
    // master side
    output logic                    m_tvalid,
    input  wire                     m_tready,
    output logic [M_TDATA_W-1:0]    m_tdata,   // [0] clock_level, [1] start_level,
                                               // [10:2] pixel_index, [18:11] pixel_value,
                                               // [19] busy_res, [23:20] zero
    output logic                    m_tuser,   // [0] pixel_valid
    output logic                    m_tlast    // last_pixel
);

    srs_state_t       state_reg;
    srs_state_t       state_next;
    srs_result_t      result_reg;
    srs_result_t      result_next;
    logic             out_valid_reg;
    logic [START_W-1:0] start_pulses_reg;
    logic             in_fire;

    // configuration always taken; start pulse count worked out on the write
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pulses_reg <= START_PULSES_RST;
        end
        else if (cfg_valid)
        begin
            start_pulses_reg <= start_pulses(cfg_data);
        end
    end

    // input is taken whenever the output register is empty or being drained
    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    srs_step #(
        .PIXEL_COUNT (PIXEL_COUNT),
        .LEAD_CLOCKS (LEAD_CLOCKS)
    ) u_srs_step (
        .cur            (state_reg),
        .op             (s_tuser),
        .video_sample   (s_tdata[SAMPLE_W-1:0]),
        .start_pulses_n (start_pulses_reg),
        .nxt            (state_next),
        .res            (result_next)
    );

    // sequencer state advances once per accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: PH_IDLE, pulse_counter: '0, half_period_flag: 1'b0,
                           clock_line: 1'b0, start_line: 1'b0};
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, result_reg.busy_res, result_reg.pixel_value,
                       result_reg.pixel_index, result_reg.start_level, result_reg.clock_level};
    assign m_tuser  = result_reg.pixel_valid;
    assign m_tlast  = result_reg.last_pixel;

endmodule

`default_nettype wire

FILE: design/srs_checker.sv
// port-level checker for the readout sequencer, bound to the top level
`default_nettype none
`include "spectrometer_readout_sequencer_top_defines.svh"

module srs_checker
    import srs_pkg::*;
(
    input wire                  clk,
    input wire                  rst_n,
    input wire                  m_tvalid,
    input wire                  m_tready,
    input wire [M_TDATA_W-1:0]  m_tdata,
    input wire                  m_tuser,
    input wire                  m_tlast
);

    // a stalled result holds its payload
    `SRS_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    // the last mark only comes with a pixel and ends the readout
    `SRS_ASSERT_SAME(a_last_ends, clk, rst_n, m_tvalid && m_tlast, m_tuser && !m_tdata[19] && !m_tdata[0], "last pixel without idle end")

    // a pixel that is not the last leaves the clock high and the readout running
    `SRS_ASSERT_SAME(a_pix_mid, clk, rst_n, m_tvalid && m_tuser && !m_tlast, m_tdata[19] && m_tdata[0], "mid pixel with wrong levels")

    // start is never high outside a readout or on a pixel
    `SRS_ASSERT_SAME(a_start_busy, clk, rst_n, m_tvalid && m_tdata[1], m_tdata[19] && !m_tuser, "start high while idle or on a pixel")

endmodule

bind spectrometer_readout_sequencer_top srs_checker u_srs_checker (.*);

`default_nettype wire

FILE: bench/spectrometer_readout_sequencer_top_test.sv
// self-checking bench for the linear sensor readout sequencer: stream driver, monitor, predictor
`default_nettype none

module spectrometer_readout_sequencer_top_test
    import srs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // sensor geometry used by both the instance and the predictor
    localparam int NUM_PIXELS = DEF_PIXEL_COUNT;
    localparam int NUM_LEAD   = DEF_LEAD_CLOCKS;

    // integration time floor and the offset taken off the quarter time
    localparam logic [CFG_W-1:0] FLOOR_US   = 20'd216;
    localparam logic [CFG_W-1:0] PULSE_TRIM = 20'd48;
    localparam logic [CFG_W-1:0] TIME_MAX   = 20'hFFFFF;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
    localparam int HOLD_AT_ITEMS = 200;   // slave transactions before the hold-off starts
    localparam int MAX_REPORTS   = 10;

    // one slave transaction: op in tuser, video sample in tdata
    typedef struct {
        logic                op;
        logic [SAMPLE_W-1:0] video;
    } tick_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data = '0;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // [7:0] video_sample
    logic                 s_tuser = 1'b0; // [0] op

    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // [0] clock, [1] start, [10:2] index,
                                          // [18:11] value, [19] busy, [23:20] zero
    logic                 m_tuser;        // [0] pixel_valid
    logic                 m_tlast;        // last_pixel

    spectrometer_readout_sequencer_top #(
        .PIXEL_COUNT (NUM_PIXELS),
        .LEAD_CLOCKS (NUM_LEAD)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor of the sequencer: own copy of register and state
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] integ_time_us = 20'd216;
    phase_t           seq_phase     = PH_IDLE;
    logic [CNT_W-1:0] seq_count     = '0;
    logic             seq_high      = 1'b0;   // clock in its high tick
    logic             line_clk      = 1'b0;
    logic             line_start    = 1'b0;

    // number of clock pulses that start stays high for a given time
    function automatic logic [CNT_W-1:0] start_pulse_count(input logic [CFG_W-1:0] t);
        logic [CFG_W-1:0] t_eff;
        t_eff = (t < FLOOR_US) ? FLOOR_US : t;
        return (t_eff >> 2) - PULSE_TRIM;
    endfunction

    // advance the predicted sequencer by one accepted transaction
    function automatic srs_result_t sequence_step(input logic op,
                                                  input logic [SAMPLE_W-1:0] video);
        srs_result_t r;
        r = '0;
        if (op == OP_BEGIN) begin
            // a begin is not a tick; while busy it leaves everything as it is
            if (seq_phase == PH_IDLE) begin
                line_clk   = 1'b1;
                line_start = 1'b0;
                seq_count  = '0;
                seq_high   = 1'b1;
                seq_phase  = PH_FIRST;
            end
        end else begin
            case (seq_phase)
                PH_FIRST: begin
                    line_clk   = 1'b0;
                    line_start = 1'b1;
                    seq_count  = '0;
                    seq_high   = 1'b0;
                    seq_phase  = PH_INTEG;
                end
                PH_INTEG: begin
                    if (!seq_high) begin
                        line_clk = 1'b1;
                        seq_high = 1'b1;
                    end else begin
                        line_clk  = 1'b0;
                        seq_high  = 1'b0;
                        seq_count = seq_count + 1'b1;
                        // register read live, so a rewrite can cut the phase short
                        if (seq_count >= start_pulse_count(integ_time_us)) begin
                            line_start = 1'b0;
                            seq_count  = '0;
                            seq_phase  = PH_GAP;
                        end
                    end
                end
                PH_GAP: begin
                    line_clk  = 1'b1;
                    seq_high  = 1'b1;
                    seq_count = '0;
                    seq_phase = (NUM_LEAD > 0) ? PH_LEAD : PH_PIXEL;
                end
                PH_LEAD: begin
                    if (seq_high) begin
                        line_clk = 1'b0;
                        seq_high = 1'b0;
                    end else begin
                        seq_count = seq_count + 1'b1;
                        line_clk  = 1'b1;
                        seq_high  = 1'b1;
                        if (seq_count >= CNT_W'(NUM_LEAD)) begin
                            seq_count = '0;
                            seq_phase = PH_PIXEL;
                        end
                    end
                end
                PH_PIXEL: begin
                    if (seq_high) begin
                        line_clk = 1'b0;
                        seq_high = 1'b0;
                    end else begin
                        // sample taken at the end of the low tick
                        r.pixel_valid = 1'b1;
                        r.pixel_index = seq_count[PIX_IDX_W-1:0];
                        r.pixel_value = video;
                        seq_count     = seq_count + 1'b1;
                        if (seq_count >= CNT_W'(NUM_PIXELS)) begin
                            r.last_pixel = 1'b1;
                            seq_count    = '0;
                            line_clk     = 1'b0;
                            seq_high     = 1'b0;
                            seq_phase    = PH_IDLE;
                        end else begin
                            line_clk = 1'b1;
                            seq_high = 1'b1;
                        end
                    end
                end
                default: ;   // ticks while idle change nothing
            endcase
        end
        r.clock_level = line_clk;
        r.start_level = line_start;
        r.busy_res    = (seq_phase != PH_IDLE);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // slave side driver: bursts of transactions with random gaps
    // ------------------------------------------------------------------
    tick_item_t tick_queue[$];
    tick_item_t next_tick;
    logic       s_fire = 1'b0;    // slave transaction seen at the last rising edge
    int         burst_left = 0;
    int         gap_left = 0;

    always @(negedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_fire) begin
            // transaction not taken yet, hold it steady
        end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            s_tvalid <= 1'b0;
        end else if (tick_queue.size() != 0) begin
            next_tick = tick_queue.pop_front();
            s_tvalid  <= 1'b1;
            s_tuser   <= next_tick.op;
            s_tdata   <= next_tick.video;
            if (burst_left <= 1) begin
                // half the bursts run straight into the next one
                burst_left <= $urandom_range(1, 40);
                gap_left   <= ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // master side stalls: a changing pattern plus one long hold-off
    // ------------------------------------------------------------------
    int   items_in = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    int   rx_mode = 0;
    int   rx_mode_left = 0;
    int   rx_phase = 0;

    // the hold-off counts its own cycles once enough items have gone in
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && items_in >= HOLD_AT_ITEMS) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(negedge clk) begin
        if (hold_left != 0) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(16, 128);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0:       m_tready <= 1'b1;                           // no stalls
                1:       m_tready <= $urandom_range(0, 1);           // coin toss
                2:       m_tready <= ((rx_phase % 4) != 0);          // one in four
                default: m_tready <= ($urandom_range(0, 3) == 0);    // mostly stalled
            endcase
            rx_phase <= rx_phase + 1;
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on slave transactions, check master transactions
    // ------------------------------------------------------------------
    srs_result_t readout_results_q[$];
    srs_result_t seen;
    srs_result_t want;
    int          mismatches = 0;
    int          results_out = 0;
    int          pixels_seen = 0;
    int          frames_seen = 0;

    function automatic void report_mismatch(input string what, input srs_result_t w,
                                            input srs_result_t g);
        if (mismatches < MAX_REPORTS)
            $display("%s: exp clk %0b start %0b pv %0b idx %0d val %0d last %0b busy %0b | got clk %0b start %0b pv %0b idx %0d val %0d last %0b busy %0b pad %h",
                     what, w.clock_level, w.start_level, w.pixel_valid, w.pixel_index,
                     w.pixel_value, w.last_pixel, w.busy_res, g.clock_level, g.start_level,
                     g.pixel_valid, g.pixel_index, g.pixel_value, g.last_pixel, g.busy_res,
                     m_tdata[23:20]);
        mismatches++;
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            s_fire <= 1'b0;
        end else begin
            // check first, so a result never meets the expectation of its own edge
            if (m_tvalid && m_tready) begin
                seen.clock_level = m_tdata[0];
                seen.start_level = m_tdata[1];
                seen.pixel_index = m_tdata[10:2];
                seen.pixel_value = m_tdata[18:11];
                seen.busy_res    = m_tdata[19];
                seen.pixel_valid = m_tuser;
                seen.last_pixel  = m_tlast;
                if (readout_results_q.size() == 0) begin
                    report_mismatch("unexpected transaction", '0, seen);
                end else begin
                    want = readout_results_q.pop_front();
                    if (seen.clock_level !== want.clock_level ||
                        seen.start_level !== want.start_level ||
                        seen.pixel_valid !== want.pixel_valid ||
                        seen.pixel_index !== want.pixel_index ||
                        seen.pixel_value !== want.pixel_value ||
                        seen.last_pixel  !== want.last_pixel  ||
                        seen.busy_res    !== want.busy_res    ||
                        m_tdata[23:20]   !== 4'd0)
                        report_mismatch("mismatch", want, seen);
                end
                if (m_tuser)
                    pixels_seen++;
                if (m_tlast)
                    frames_seen++;
                results_out++;
            end
            if (s_tvalid && s_tready) begin
                readout_results_q.push_back(sequence_step(s_tuser, s_tdata));
                items_in <= items_in + 1;
            end
            s_fire <= s_tvalid && s_tready;
        end
    end

    // global watchdog
    int cycles = 0;

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    int items_queued = 0;
    int settings_used = 0;

    task automatic queue_tick(input logic op, input logic [SAMPLE_W-1:0] video);
        tick_item_t it;
        it.op    = op;
        it.video = video;
        tick_queue.push_back(it);
        items_queued++;
    endtask

    // wait until every queued transaction has gone in and its result come out
    task automatic wait_for_drain();
        while (tick_queue.size() != 0 || s_tvalid || readout_results_q.size() != 0)
            @(posedge clk);
    endtask

    // single write on the configuration channel; the bench is drained when called
    task automatic write_integration_time(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        integ_time_us = value;
        settings_used++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // tick in small chunks until the predicted readout is over
    task automatic finish_readout();
        while (seq_phase != PH_IDLE) begin
            repeat (16)
                queue_tick(OP_TICK, SAMPLE_W'($urandom));
            wait_for_drain();
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // ticks while idle leave the lines low, sample extremes on the bus
        queue_tick(OP_TICK, 8'h00);
        queue_tick(OP_TICK, 8'hFF);
        queue_tick(OP_TICK, 8'h55);
        queue_tick(OP_TICK, 8'hAA);
        // begin from idle raises the clock at once, a second begin is ignored
        queue_tick(OP_BEGIN, 8'hFF);
        queue_tick(OP_BEGIN, 8'h00);
        queue_tick(OP_TICK, 8'h5A);
        queue_tick(OP_BEGIN, 8'hA5);
        // three start pulses at the reset setting
        repeat (6)
            queue_tick(OP_TICK, SAMPLE_W'($urandom));
        wait_for_drain();
        // longest time mid-readout: start stays high beyond the old count
        write_integration_time(TIME_MAX);
        repeat (10)
            queue_tick(OP_TICK, SAMPLE_W'($urandom));
        wait_for_drain();
        // back to the floor: the count is already past the new limit
        write_integration_time('0);
        finish_readout();

        wait_for_drain();
        repeat (20) @(posedge clk);
        if (readout_results_q.size() != 0)
            mismatches++;

        $display("run: %0d items in, %0d results checked, %0d pixels in %0d readouts",
                 items_in, results_out, pixels_seen, frames_seen);
        $display("run: %0d integration settings, %0d mismatches", settings_used, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+design
design/srs_pkg.sv
design/srs_step.sv
design/spectrometer_readout_sequencer_top.sv
design/srs_checker.sv
bench/spectrometer_readout_sequencer_top_test.sv
